// ===== design/grid_layer_rotator_macros.svh =====
// shared assertion macros for the grid layer rotator
`ifndef GRID_LAYER_ROTATOR_MACROS_SVH
`define GRID_LAYER_ROTATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define GRL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid layer rotator: check failed");

// next-cycle implication, checked out of reset
`define GRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid layer rotator: check failed");

`endif

// ===== design/grl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package grl_pkg;

    // grid geometry and storage
    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int VALUE_BITS  = 16;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TOT_W       = ADDR_W + 1;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int DIM_W       = 7;
    localparam int SHIFT_W     = 30;
    localparam int LEN_W       = 8;
    localparam int DIV_CNT_W   = 5;
    localparam int PAD_W       = SHIFT_W - ADDR_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_AMOUNT = 2'd2;

    // reset values of the configuration registers
    localparam logic [DIM_W-1:0]   RST_ROWS  = 7'd4;
    localparam logic [DIM_W-1:0]   RST_COLS  = 7'd4;
    localparam logic [SHIFT_W-1:0] RST_SHIFT = '0;

    // command opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // divider launch request
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_ctl_t;

    // grid memory access
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [VALUE_BITS-1:0] wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } ram_req_t;

    // saturate a dimension to [2, hi]
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        begin
            if (v < 7'd2)
            begin
                res = 7'd2;
            end
            else if (v > hi)
            begin
                res = hi;
            end
            else
            begin
                res = v;
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/grid_layer_rotator.sv =====
// channel   direction  beat marker              payload
// command   in         start & !busy            opcode, cell_value
// result    out        done (one cycle)         out_value, is_last
// config    in         cfg_valid & cfg_ready    cfg_index, cfg_data
//
// a load beat is taken and written to the grid memory at once
// a fetch beat holds busy through its result beat (the second divide is skipped for a cell outside every full ring):
// a 12-step divide splits the pointer into row and column, a 30-step divide
// reduces the shift modulo the ring length, then one memory read
// done pulses in the last busy cycle; the receiver cannot stall it
// reset clears pointers and restores the default configuration; memory contents stay undefined
`timescale 1ns / 1ps
`default_nettype none

`include "grid_layer_rotator_macros.svh"

module grid_layer_rotator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               opcode,
    input  wire logic [grl_pkg::VALUE_BITS-1:0]     cell_value,
    output logic                                    done,
    output logic [grl_pkg::VALUE_BITS-1:0]          out_value,
    output logic                                    is_last,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [grl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [grl_pkg::SHIFT_W-1:0]        cfg_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIV_RC = 4'd1;
    localparam logic [3:0] ST_RING_A = 4'd2;
    localparam logic [3:0] ST_RING_B = 4'd3;
    localparam logic [3:0] ST_DIV_SH = 4'd4;
    localparam logic [3:0] ST_MAP_A  = 4'd5;
    localparam logic [3:0] ST_MAP_B  = 4'd6;
    localparam logic [3:0] ST_READ   = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    localparam int DW = grl_pkg::DIM_W;
    localparam int LW = grl_pkg::LEN_W;
    localparam int AW = grl_pkg::ADDR_W;
    localparam int TW = grl_pkg::TOT_W;
    localparam int RW = grl_pkg::ROW_W;
    localparam int CW = grl_pkg::COL_W;

    logic [3:0]    state_reg, state_next;

    logic [DW-1:0]                 rows_cfg_reg, cols_cfg_reg;
    logic [grl_pkg::SHIFT_W-1:0]   shift_cfg_reg;
    logic [AW-1:0]                 load_ptr_reg, load_ptr_next;
    logic [AW-1:0]                 fetch_ptr_reg, fetch_ptr_next;
    logic [AW-1:0]                 cur_ptr_reg;

    logic [DW-1:0]       rows, cols;
    logic [2*DW-1:0]     area;
    logic [TW-1:0]       total;
    logic                accept, load_acc, fetch_acc;
    logic [AW-1:0]       load_eff, fetch_eff;
    logic [TW-1:0]       load_inc, fetch_inc;

    grl_pkg::div_ctl_t             div_ctl;
    logic [grl_pkg::SHIFT_W-1:0]   div_dividend;
    logic [LW-1:0]                 div_divisor;
    logic                          div_done;
    logic [grl_pkg::SHIFT_W-1:0]   div_quot;
    logic [LW-1:0]                 div_rem;

    grl_pkg::ram_req_t             ram_req;
    logic [grl_pkg::VALUE_BITS-1:0] ram_rdata;

    // ring geometry registers
    logic [DW-1:0]   r_reg, c_reg, d_reg, bottom_reg, right_reg;
    logic            pass_reg;
    logic [LW-1:0]   len_reg, q_reg, e1_reg, e2_reg, e3_reg, p_reg;
    logic [RW-1:0]   sr_reg;
    logic [CW-1:0]   sc_reg;

    logic [DW-1:0]   a_r, a_c, a_rb, a_cr, a_m1, a_m2, a_d, a_rings;
    logic [DW-1:0]   b_h, b_w, b_hm1, b_wm1;
    logic [LW-1:0]   b_len, b_e1, b_e2, b_e3, b_q;
    logic [LW:0]     m_t;
    logic [LW-1:0]   m_p;
    logic [LW-1:0]   n_sr, n_sc;
    logic [2*DW-1:0] rd_prod;
    logic [2*DW-1:0] rd_addr;

    // clamped geometry
    assign rows  = grl_pkg::clamp_dim(rows_cfg_reg, DW'(grl_pkg::MAX_ROWS));
    assign cols  = grl_pkg::clamp_dim(cols_cfg_reg, DW'(grl_pkg::MAX_COLS));
    assign area  = (2*DW)'(rows) * (2*DW)'(cols);
    assign total = area[TW-1:0];

    // command handshake
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign load_acc  = accept && (opcode == grl_pkg::OP_LOAD);
    assign fetch_acc = accept && (opcode == grl_pkg::OP_FETCH);

    // pointers restart when beyond the current grid
    assign load_eff  = ({1'b0, load_ptr_reg} >= total) ? '0 : load_ptr_reg;
    assign fetch_eff = ({1'b0, fetch_ptr_reg} >= total) ? '0 : fetch_ptr_reg;
    assign load_inc  = {1'b0, load_eff} + 1'b1;
    assign fetch_inc = {1'b0, cur_ptr_reg} + 1'b1;

    always_comb
    begin
        load_ptr_next  = load_ptr_reg;
        fetch_ptr_next = fetch_ptr_reg;
        if (load_acc)
        begin
            load_ptr_next = (load_inc >= total) ? '0 : load_inc[AW-1:0];
        end
        if (state_reg == ST_OUT)
        begin
            fetch_ptr_next = (fetch_inc >= total) ? '0 : fetch_inc[AW-1:0];
        end
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= grl_pkg::RST_ROWS;
            cols_cfg_reg  <= grl_pkg::RST_COLS;
            shift_cfg_reg <= grl_pkg::RST_SHIFT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                grl_pkg::CFG_ROW_COUNT:    rows_cfg_reg  <= cfg_data[DW-1:0];
                grl_pkg::CFG_COL_COUNT:    cols_cfg_reg  <= cfg_data[DW-1:0];
                grl_pkg::CFG_SHIFT_AMOUNT: shift_cfg_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // shared divider: pointer by columns, then shift by ring length
    always_comb
    begin
        div_ctl      = '0;
        div_dividend = {fetch_eff, {grl_pkg::PAD_W{1'b0}}};
        div_divisor  = LW'(cols);
        if (fetch_acc)
        begin
            div_ctl.start = 1'b1;
            div_ctl.steps = grl_pkg::DIV_CNT_W'(AW);
        end
        else if ((state_reg == ST_RING_B) && !pass_reg)
        begin
            div_ctl.start = 1'b1;
            div_ctl.steps = grl_pkg::DIV_CNT_W'(grl_pkg::SHIFT_W);
            div_dividend  = shift_cfg_reg;
            div_divisor   = b_len;
        end
    end

    grl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // ring depth from row and column
    assign a_r     = DW'(div_quot[RW-1:0]);
    assign a_c     = DW'(div_rem[CW-1:0]);
    assign a_rb    = rows - 1'b1 - a_r;
    assign a_cr    = cols - 1'b1 - a_c;
    assign a_m1    = (a_r < a_c) ? a_r : a_c;
    assign a_m2    = (a_rb < a_cr) ? a_rb : a_cr;
    assign a_d     = (a_m1 < a_m2) ? a_m1 : a_m2;
    assign a_rings = ((rows >> 1) < (cols >> 1)) ? (rows >> 1) : (cols >> 1);

    // ring size and position along the ring
    assign b_h   = rows - {d_reg[DW-2:0], 1'b0};
    assign b_w   = cols - {d_reg[DW-2:0], 1'b0};
    assign b_hm1 = b_h - 1'b1;
    assign b_wm1 = b_w - 1'b1;
    assign b_len = {b_h, 1'b0} + {b_w, 1'b0} - 8'd4;
    assign b_e1  = LW'(b_hm1);
    assign b_e2  = LW'(b_hm1) + LW'(b_wm1);
    assign b_e3  = {b_hm1, 1'b0} + LW'(b_wm1);

    always_comb
    begin
        if (c_reg == d_reg)
        begin
            b_q = LW'(r_reg - d_reg);
        end
        else if (r_reg == bottom_reg)
        begin
            b_q = b_e1 + LW'(c_reg - d_reg);
        end
        else if (c_reg == right_reg)
        begin
            b_q = b_e2 + LW'(bottom_reg - r_reg);
        end
        else
        begin
            b_q = b_e3 + LW'(right_reg - c_reg);
        end
    end

    // source position: (q + len - s) mod len, one compare and subtract
    assign m_t = {1'b0, q_reg} + {1'b0, len_reg} - {1'b0, div_rem};
    assign m_p = (m_t >= {1'b0, len_reg}) ? LW'(m_t - {1'b0, len_reg}) : m_t[LW-1:0];

    // position back to source cell
    always_comb
    begin
        if (p_reg < e1_reg)
        begin
            n_sr = LW'(d_reg) + p_reg;
            n_sc = LW'(d_reg);
        end
        else if (p_reg < e2_reg)
        begin
            n_sr = LW'(bottom_reg);
            n_sc = LW'(d_reg) + (p_reg - e1_reg);
        end
        else if (p_reg < e3_reg)
        begin
            n_sr = LW'(bottom_reg) - (p_reg - e2_reg);
            n_sc = LW'(right_reg);
        end
        else
        begin
            n_sr = LW'(d_reg);
            n_sc = LW'(right_reg) - (p_reg - e3_reg);
        end
    end

    // row-major source address
    assign rd_prod = (2*DW)'(sr_reg) * (2*DW)'(cols);
    assign rd_addr = rd_prod + (2*DW)'(sc_reg);

    // grid memory port
    always_comb
    begin
        ram_req       = '0;
        ram_req.we    = load_acc;
        ram_req.waddr = load_eff;
        ram_req.wdata = cell_value;
        ram_req.re    = (state_reg == ST_READ);
        ram_req.raddr = rd_addr[AW-1:0];
    end

    grl_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // fetch sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   state_next = fetch_acc ? ST_DIV_RC : ST_IDLE;
            ST_DIV_RC: state_next = div_done ? ST_RING_A : ST_DIV_RC;
            ST_RING_A: state_next = ST_RING_B;
            ST_RING_B: state_next = pass_reg ? ST_READ : ST_DIV_SH;
            ST_DIV_SH: state_next = div_done ? ST_MAP_A : ST_DIV_SH;
            ST_MAP_A:  state_next = ST_MAP_B;
            ST_MAP_B:  state_next = ST_READ;
            ST_READ:   state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            load_ptr_reg  <= '0;
            fetch_ptr_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            load_ptr_reg  <= load_ptr_next;
            fetch_ptr_reg <= fetch_ptr_next;
        end
    end

    // datapath registers per step
    always_ff @(posedge clk)
    begin
        if (fetch_acc)
        begin
            cur_ptr_reg <= fetch_eff;
        end
        if (state_reg == ST_RING_A)
        begin
            r_reg      <= a_r;
            c_reg      <= a_c;
            d_reg      <= a_d;
            pass_reg   <= (a_d >= a_rings);
            bottom_reg <= rows - 1'b1 - a_d;
            right_reg  <= cols - 1'b1 - a_d;
        end
        if (state_reg == ST_RING_B)
        begin
            len_reg <= b_len;
            q_reg   <= b_q;
            e1_reg  <= b_e1;
            e2_reg  <= b_e2;
            e3_reg  <= b_e3;
            if (pass_reg)
            begin
                sr_reg <= r_reg[RW-1:0];
                sc_reg <= c_reg[CW-1:0];
            end
        end
        if (state_reg == ST_MAP_A)
        begin
            p_reg <= m_p;
        end
        if (state_reg == ST_MAP_B)
        begin
            sr_reg <= n_sr[RW-1:0];
            sc_reg <= n_sc[CW-1:0];
        end
    end

    // result beat
    assign done      = (state_reg == ST_OUT);
    assign out_value = ram_rdata;
    assign is_last   = done && ({1'b0, cur_ptr_reg} == (total - 1'b1));

    `GRL_ASSERT_NEXT(a_fetch_busy, clk, rst_n, fetch_acc, busy)
    `GRL_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `GRL_ASSERT_IMPLIES(a_src_row, clk, rst_n, state_reg == ST_READ, DW'(sr_reg) < rows)
    `GRL_ASSERT_IMPLIES(a_src_col, clk, rst_n, state_reg == ST_READ, DW'(sc_reg) < cols)

endmodule

`default_nettype wire

// ===== design/grl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module grl_ram (
    input  wire logic                            clk,
    input  wire grl_pkg::ram_req_t               req,
    output logic [grl_pkg::VALUE_BITS-1:0]       rdata
);

    logic [grl_pkg::VALUE_BITS-1:0] mem [grl_pkg::STORE_DEPTH];

    // one write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // one read port, registered data
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/grl_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "grid_layer_rotator_macros.svh"

module grl_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire grl_pkg::div_ctl_t              ctl,
    input  wire logic [grl_pkg::SHIFT_W-1:0]    dividend,
    input  wire logic [grl_pkg::LEN_W-1:0]      divisor,
    output logic                                done,
    output logic [grl_pkg::SHIFT_W-1:0]         quotient,
    output logic [grl_pkg::LEN_W-1:0]           remainder
);

    logic                            busy_reg, busy_next;
    logic [grl_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [grl_pkg::SHIFT_W-1:0]     dq_reg;
    logic [grl_pkg::LEN_W-1:0]       rem_reg;
    logic [grl_pkg::LEN_W-1:0]       dvs_reg;
    logic [grl_pkg::LEN_W:0]         trial;
    logic                            fits;
    logic [grl_pkg::LEN_W:0]         diff;

    // restoring step: bring down one dividend bit
    assign trial = {rem_reg, dq_reg[grl_pkg::SHIFT_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    // step counter control
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ctl.steps;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // quotient shifts in at the bottom as the dividend shifts out at the top
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[grl_pkg::SHIFT_W-2:0], fits};
            rem_reg <= fits ? diff[grl_pkg::LEN_W-1:0] : trial[grl_pkg::LEN_W-1:0];
        end
    end

    assign done      = busy_reg && (cnt_reg == 5'd1);
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

    `GRL_ASSERT_IMPLIES(a_no_restart, clk, rst_n, ctl.start, !busy_reg)
    `GRL_ASSERT_IMPLIES(a_cnt_live, clk, rst_n, busy_reg, cnt_reg != '0)
    `GRL_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy_reg)

endmodule

`default_nettype wire
